// ===== src/sshm_pkg.sv =====
// Shared types, constants and helpers for the skid-steer heading-hold mixer.
// No dependencies; used by every module under src.
package sshm_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	localparam int MUL_A_W = 21;
	localparam int MUL_B_W = 32;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = 56;

	localparam int DIV_NUM_W = 32;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = 6;
	localparam int DIV_STEPS = DIV_NUM_W;

	localparam logic signed [16:0] ANG_PI     = 17'sd25736;
	localparam logic signed [16:0] ANG_TWO_PI = 17'sd51472;

	localparam logic [14:0] SPEED_LIM_RST  = 15'd4506;
	localparam logic [14:0] HALF_TRACK_RST = 15'd1024;
	localparam logic [19:0] GAIN_P_RST     = 20'd2294;
	localparam logic [19:0] GAIN_I_RST     = 20'd3277;
	localparam logic [19:0] GAIN_D_RST     = 20'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPEED_LIM   = 3'd0,
		REG_HALF_TRACK  = 3'd1,
		REG_GAIN_P      = 3'd2,
		REG_GAIN_I      = 3'd3,
		REG_GAIN_D      = 3'd4,
		REG_HOLD_ENABLE = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		CLS_FORWARD  = 2'd0,
		CLS_BACKWARD = 2'd1,
		CLS_STOPPED  = 2'd2,
		CLS_TURNING  = 2'd3
	} motion_cls_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TURN,
		ST_MIX,
		ST_INT_MUL,
		ST_INT_ACC,
		ST_DIV_WAIT,
		ST_P_MUL,
		ST_I_MUL,
		ST_D_MUL,
		ST_D_ACC,
		ST_CHECK,
		ST_APPLY,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic signed [15:0] linear_speed;
		logic signed [15:0] turn_rate;
		logic signed [15:0] heading;
		logic        [15:0] time_step;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] right_speed;
		logic signed [15:0] left_speed;
		logic               motor_enable;
		logic               overshoot;
	} out_item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] dividend;
		logic [DIV_DEN_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 busy;
		logic                 done;
		logic [DIV_NUM_W-1:0] quotient;
	} div_rsp_t;

	// clamp to plus or minus an unsigned limit
	function automatic logic signed [15:0] clamp_lim(input logic signed [20:0] x,
		input logic [14:0] lim);
		logic signed [20:0] hi;
		logic signed [20:0] lo;
		hi = $signed({6'b0, lim});
		lo = -hi;
		if (x > hi) begin
			return hi[15:0];
		end else if (x < lo) begin
			return lo[15:0];
		end else begin
			return x[15:0];
		end
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [32:0] x);
		if (x > 33'sh0_7FFF_FFFF) begin
			return 32'sh7FFF_FFFF;
		end else if (x < -33'sh0_8000_0000) begin
			return 32'sh8000_0000;
		end else begin
			return x[31:0];
		end
	endfunction

endpackage

// ===== src/sshm_mul.sv =====
// Shared signed multiplier with registered product.
// Depends on sshm_pkg for operand widths.
module sshm_mul (
	input  logic                                clk,
	input  logic signed [sshm_pkg::MUL_A_W-1:0] a,
	input  logic signed [sshm_pkg::MUL_B_W-1:0] b,
	output logic signed [sshm_pkg::PROD_W-1:0]  product
);

	logic signed [sshm_pkg::PROD_W-1:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= a * b;
	end

	assign product = product_q;

endmodule

// ===== src/sshm_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on sshm_pkg for request and response types.
module sshm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sshm_pkg::div_req_t req,
	output sshm_pkg::div_rsp_t rsp
);

	logic [sshm_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                           done_q;
	logic [sshm_pkg::DIV_NUM_W-1:0] quo_q;
	logic [sshm_pkg::DIV_DEN_W-1:0] rem_q;
	logic [sshm_pkg::DIV_DEN_W-1:0] den_q;
	logic [sshm_pkg::DIV_DEN_W:0]   trial;
	logic                           take;

	assign trial = {rem_q, quo_q[sshm_pkg::DIV_NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == sshm_pkg::DIV_CNT_W'(1));
			if (req.start) begin
				cnt_q <= sshm_pkg::DIV_CNT_W'(sshm_pkg::DIV_STEPS);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (cnt_q != '0) begin
			// remainder stays below the divisor, so the top trial bit drops out
			rem_q <= take ? sshm_pkg::DIV_DEN_W'(trial - {1'b0, den_q})
			              : trial[sshm_pkg::DIV_DEN_W-1:0];
			quo_q <= {quo_q[sshm_pkg::DIV_NUM_W-2:0], take};
		end
	end

	assign rsp.busy     = cnt_q != '0;
	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== src/skid_steer_heading_hold_mixer.sv =====
// Skid-steer mixer with PID heading hold, one shared multiplier and a bit-serial divider.
// Without correction a transaction passes the turn and mix states; with the PID running it
// also waits on the 32-step derivative division. One transaction at a time: a finished result
// waits only while the output register still holds a stalled one, and then blocks the input.
// Reset (arst_n, asynchronous): registers to defaults, class stopped, PID history cleared.
module skid_steer_heading_hold_mixer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  sshm_pkg::in_item_t                  in_item,
	output logic                                out_valid,
	input  logic                                out_stall,
	output sshm_pkg::out_item_t                 out_item,
	input  logic                                cfg_write_enable,
	input  logic [sshm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [sshm_pkg::CFG_DATA_W-1:0]     cfg_data
);

	// configuration
	logic [14:0] speed_lim_q;
	logic [14:0] half_track_q;
	logic [19:0] gain_p_q;
	logic [19:0] gain_i_q;
	logic [19:0] gain_d_q;
	logic        hold_enable_q;

	// sequencer and architectural state
	sshm_pkg::seq_state_t  state_q;
	sshm_pkg::seq_state_t  state_d;
	sshm_pkg::motion_cls_t last_cls_q;
	sshm_pkg::motion_cls_t cls_c;
	logic signed [15:0]    target_q;
	logic signed [16:0]    last_error_q;
	logic signed [31:0]    error_sum_q;
	logic                  out_valid_q;
	sshm_pkg::out_item_t   out_q;

	// transaction payload
	logic signed [15:0] v_q;
	logic signed [15:0] w_q;
	logic signed [15:0] hdg_q;
	logic        [15:0] dt_q;
	logic               pid_run_q;
	logic               zero_cmd_q;
	logic signed [15:0] err_q;
	logic               div_neg_q;
	logic signed [31:0] deriv_q;
	logic signed [sshm_pkg::ACC_W-1:0] acc_q;
	logic signed [16:0] u_q;
	logic               over_q;
	logic signed [15:0] right_q;
	logic signed [15:0] left_q;

	// shared units
	logic signed [sshm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [sshm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [sshm_pkg::PROD_W-1:0]  prod;
	sshm_pkg::div_req_t                  div_req;
	sshm_pkg::div_rsp_t                  div_rsp;

	// combinational datapath
	logic               in_take;
	logic               out_load;
	logic signed [15:0] v_c;
	logic signed [15:0] w_c;
	logic signed [sshm_pkg::PROD_W-1:0] turn_full;
	logic signed [19:0] turn;
	logic signed [16:0] hdiff;
	logic signed [16:0] err_wrap;
	logic signed [sshm_pkg::PROD_W-1:0] int_full;
	logic signed [18:0] int_inc;
	logic signed [17:0] ddiff;
	logic        [17:0] dmag;
	logic        [31:0] dq;
	logic signed [31:0] deriv_c;
	logic signed [sshm_pkg::ACC_W-1:0] bound;
	logic signed [sshm_pkg::ACC_W-1:0] u_full;
	logic               over_c;

	sshm_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.product (prod)
	);

	sshm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall  = state_q != sshm_pkg::ST_IDLE;
	assign in_take   = in_valid && !in_stall;
	assign out_load  = (state_q == sshm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	assign v_c = sshm_pkg::clamp_lim(21'(in_item.linear_speed), speed_lim_q);
	assign w_c = sshm_pkg::clamp_lim(21'(in_item.turn_rate), speed_lim_q);

	always_comb begin
		if (w_c != '0) begin
			cls_c = sshm_pkg::CLS_TURNING;
		end else if (v_c > 16'sd0) begin
			cls_c = sshm_pkg::CLS_FORWARD;
		end else if (v_c < 16'sd0) begin
			cls_c = sshm_pkg::CLS_BACKWARD;
		end else begin
			cls_c = sshm_pkg::CLS_STOPPED;
		end
	end

	// rounding shifts: ties go towards plus infinity
	assign turn_full = (prod + sshm_pkg::PROD_W'(2048)) >>> 12;
	assign turn      = turn_full[19:0];
	assign int_full  = (prod + sshm_pkg::PROD_W'(4096)) >>> 13;
	assign int_inc   = int_full[18:0];

	// error range is bounded, one correction step wraps it into (-pi, pi]
	assign hdiff = 17'(target_q) - 17'(hdg_q);
	always_comb begin
		if (hdiff > sshm_pkg::ANG_PI) begin
			err_wrap = hdiff - sshm_pkg::ANG_TWO_PI;
		end else if (hdiff <= -sshm_pkg::ANG_PI) begin
			err_wrap = hdiff + sshm_pkg::ANG_TWO_PI;
		end else begin
			err_wrap = hdiff;
		end
	end

	assign ddiff = 18'(err_q) - 18'(last_error_q);
	assign dmag  = ddiff[17] ? 18'(-ddiff) : 18'(ddiff);
	assign dq    = div_rsp.quotient;

	// truncating signed quotient, saturated to 32 bits
	always_comb begin
		if (div_neg_q) begin
			deriv_c = (dq[31] && (dq[30:0] != '0)) ? 32'sh8000_0000 : $signed(~dq + 32'd1);
		end else begin
			deriv_c = dq[31] ? 32'sh7FFF_FFFF : $signed(dq);
		end
	end

	assign bound  = $signed({24'b0, speed_lim_q, 17'b0});
	assign over_c = (acc_q > bound) || (acc_q < -bound);
	assign u_full = (acc_q + sshm_pkg::ACC_W'(65536)) >>> 17;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sshm_pkg::ST_IDLE:     if (in_valid) begin
				state_d = sshm_pkg::ST_TURN;
			end
			sshm_pkg::ST_TURN:     state_d = sshm_pkg::ST_MIX;
			sshm_pkg::ST_MIX:      state_d = pid_run_q ? sshm_pkg::ST_INT_MUL : sshm_pkg::ST_DONE;
			sshm_pkg::ST_INT_MUL:  state_d = sshm_pkg::ST_INT_ACC;
			sshm_pkg::ST_INT_ACC:  state_d = sshm_pkg::ST_DIV_WAIT;
			sshm_pkg::ST_DIV_WAIT: if (div_rsp.done) begin
				state_d = sshm_pkg::ST_P_MUL;
			end
			sshm_pkg::ST_P_MUL:    state_d = sshm_pkg::ST_I_MUL;
			sshm_pkg::ST_I_MUL:    state_d = sshm_pkg::ST_D_MUL;
			sshm_pkg::ST_D_MUL:    state_d = sshm_pkg::ST_D_ACC;
			sshm_pkg::ST_D_ACC:    state_d = sshm_pkg::ST_CHECK;
			sshm_pkg::ST_CHECK:    state_d = sshm_pkg::ST_APPLY;
			sshm_pkg::ST_APPLY:    state_d = sshm_pkg::ST_DONE;
			sshm_pkg::ST_DONE:     if (out_load) begin
				state_d = sshm_pkg::ST_IDLE;
			end
			default:               state_d = sshm_pkg::ST_IDLE;
		endcase
	end

	// unit operands and divider start
	always_comb begin
		mul_a            = '0;
		mul_b            = '0;
		div_req.start    = 1'b0;
		div_req.dividend = {dmag[15:0], 16'b0};
		div_req.divisor  = dt_q;
		unique case (state_q)
			sshm_pkg::ST_TURN: begin
				mul_a = $signed({6'b0, half_track_q});
				mul_b = 32'(w_q);
			end
			sshm_pkg::ST_INT_MUL: begin
				mul_a = $signed({5'b0, dt_q});
				mul_b = 32'(err_q);
			end
			sshm_pkg::ST_INT_ACC: begin
				div_req.start = 1'b1;
			end
			sshm_pkg::ST_P_MUL: begin
				mul_a = $signed({1'b0, gain_p_q});
				mul_b = 32'(err_q);
			end
			sshm_pkg::ST_I_MUL: begin
				mul_a = $signed({1'b0, gain_i_q});
				mul_b = error_sum_q;
			end
			sshm_pkg::ST_D_MUL: begin
				mul_a = $signed({1'b0, gain_d_q});
				mul_b = deriv_q;
			end
			default: begin
			end
		endcase
	end

	// configuration port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_lim_q   <= sshm_pkg::SPEED_LIM_RST;
			half_track_q  <= sshm_pkg::HALF_TRACK_RST;
			gain_p_q      <= sshm_pkg::GAIN_P_RST;
			gain_i_q      <= sshm_pkg::GAIN_I_RST;
			gain_d_q      <= sshm_pkg::GAIN_D_RST;
			hold_enable_q <= 1'b0;
		end else if (cfg_write_enable) begin
			unique case (sshm_pkg::reg_idx_t'(cfg_index))
				sshm_pkg::REG_SPEED_LIM:   speed_lim_q   <= cfg_data[14:0];
				sshm_pkg::REG_HALF_TRACK:  half_track_q  <= cfg_data[14:0];
				sshm_pkg::REG_GAIN_P:      gain_p_q      <= cfg_data;
				sshm_pkg::REG_GAIN_I:      gain_i_q      <= cfg_data;
				sshm_pkg::REG_GAIN_D:      gain_d_q      <= cfg_data;
				sshm_pkg::REG_HOLD_ENABLE: hold_enable_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// sequencer, heading-hold state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= sshm_pkg::ST_IDLE;
			last_cls_q   <= sshm_pkg::CLS_STOPPED;
			target_q     <= '0;
			last_error_q <= '0;
			error_sum_q  <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_take) begin
				last_cls_q <= cls_c;
				if (cls_c != last_cls_q) begin
					target_q     <= in_item.heading;
					last_error_q <= '0;
					error_sum_q  <= '0;
				end
			end
			if (state_q == sshm_pkg::ST_INT_ACC) begin
				error_sum_q  <= sshm_pkg::sat32(33'(error_sum_q) + 33'(int_inc));
				last_error_q <= 17'(err_q);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_take) begin
			v_q        <= v_c;
			w_q        <= w_c;
			hdg_q      <= in_item.heading;
			dt_q       <= in_item.time_step;
			pid_run_q  <= (v_c != '0) && (w_c == '0) && hold_enable_q &&
			              (in_item.time_step != '0);
			zero_cmd_q <= (v_c == '0) && (w_c == '0);
			over_q     <= 1'b0;
		end
		unique case (state_q)
			sshm_pkg::ST_MIX: begin
				right_q <= sshm_pkg::clamp_lim(21'(v_q) + 21'(turn), speed_lim_q);
				left_q  <= sshm_pkg::clamp_lim(21'(v_q) - 21'(turn), speed_lim_q);
				err_q   <= err_wrap[15:0];
			end
			sshm_pkg::ST_INT_ACC: begin
				div_neg_q <= ddiff[17];
			end
			sshm_pkg::ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					deriv_q <= deriv_c;
				end
			end
			sshm_pkg::ST_I_MUL: begin
				acc_q <= sshm_pkg::ACC_W'(prod);
			end
			sshm_pkg::ST_D_MUL: begin
				// integral term is floored by the arithmetic shift
				acc_q <= acc_q + sshm_pkg::ACC_W'(prod >>> 3);
			end
			sshm_pkg::ST_D_ACC: begin
				acc_q <= acc_q + sshm_pkg::ACC_W'(prod);
			end
			sshm_pkg::ST_CHECK: begin
				over_q <= over_c;
				u_q    <= over_c ? 17'sd0 : u_full[16:0];
			end
			sshm_pkg::ST_APPLY: begin
				right_q <= sshm_pkg::clamp_lim(21'(right_q) + 21'(u_q), speed_lim_q);
				left_q  <= sshm_pkg::clamp_lim(21'(left_q) - 21'(u_q), speed_lim_q);
			end
			default: begin
			end
		endcase
		if (out_load) begin
			out_q.right_speed  <= zero_cmd_q ? 16'sd0 : right_q;
			out_q.left_speed   <= zero_cmd_q ? 16'sd0 : left_q;
			out_q.motor_enable <= !zero_cmd_q;
			out_q.overshoot    <= over_q;
		end
	end

`ifndef SYNTHESIS
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == sshm_pkg::ST_DONE))
		else $error("result registered outside the done state");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == sshm_pkg::ST_DIV_WAIT))
		else $error("divider finished outside its wait state");

	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy)
		else $error("divider restarted while busy");

	a_overshoot_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (!out_q.overshoot || out_q.motor_enable))
		else $error("overshoot flagged on a zero command");

	a_speed_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (($signed(out_q.right_speed) <= $signed({1'b0, speed_lim_q})) &&
		                 ($signed(out_q.right_speed) >= -$signed({1'b0, speed_lim_q}))))
		else $error("right wheel speed beyond limit");
`endif

endmodule
